@@ rtl/core/ppm_pkg.sv @@
// Shared types and constants of the particle pool manager.
// Holds the controller/datapath command and status structs and the direction table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppm_pkg;

  // Request codes
  localparam logic [1:0] REQ_FIRE    = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_REVERSE = 2'd2;
  localparam logic [1:0] REQ_READ    = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_READ = 2'd2;

  // Configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic       capture;
    logic       fs_rd;
    logic       mul_fire;
    logic       fire_commit;
    logic       list_rd_i;
    logic       list_rd_ri;
    logic       obj_rd;
    logic       mul_tick;
    logic       upd_tick;
    logic       tail_wr;
    logic       rev_wr;
    logic       emit;
    logic       emit_entry;
    logic [1:0] emit_status;
  } ppm_cmd_t;

  typedef struct packed {
    logic fs_empty;
    logic i_end;
    logic ri_bad;
    logic cull;
  } ppm_stat_t;

  typedef struct packed {
    logic signed [15:0] c;
    logic signed [15:0] s;
  } ppm_trig_t;

  // Quarter cosine in Q14, round(16384*cos(k*PI/40)) for k = 0..20
  function automatic logic signed [15:0] ppm_qcos(input logic [4:0] k);
    logic signed [15:0] v;
    unique case (k)
      5'd0:    v = 16'sd16384;
      5'd1:    v = 16'sd16333;
      5'd2:    v = 16'sd16182;
      5'd3:    v = 16'sd15931;
      5'd4:    v = 16'sd15582;
      5'd5:    v = 16'sd15137;
      5'd6:    v = 16'sd14598;
      5'd7:    v = 16'sd13970;
      5'd8:    v = 16'sd13255;
      5'd9:    v = 16'sd12458;
      5'd10:   v = 16'sd11585;
      5'd11:   v = 16'sd10641;
      5'd12:   v = 16'sd9630;
      5'd13:   v = 16'sd8561;
      5'd14:   v = 16'sd7438;
      5'd15:   v = 16'sd6270;
      5'd16:   v = 16'sd5063;
      5'd17:   v = 16'sd3825;
      5'd18:   v = 16'sd2563;
      5'd19:   v = 16'sd1285;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // Cosine and sine of step*PI/40 through quadrant symmetry; steps wrap modulo 80
  function automatic ppm_trig_t ppm_trig(input logic [6:0] step);
    logic [6:0]         k;
    logic [1:0]         q;
    logic [4:0]         r;
    logic signed [15:0] a;
    logic signed [15:0] b;
    ppm_trig_t          t;
    k = (step >= 7'd80) ? 7'(step - 7'd80) : step;
    if (k >= 7'd60) begin
      q = 2'd3;
      r = 5'(k - 7'd60);
    end else if (k >= 7'd40) begin
      q = 2'd2;
      r = 5'(k - 7'd40);
    end else if (k >= 7'd20) begin
      q = 2'd1;
      r = 5'(k - 7'd20);
    end else begin
      q = 2'd0;
      r = 5'(k);
    end
    a = ppm_qcos(r);
    b = ppm_qcos(5'(5'd20 - r));
    unique case (q)
      2'd0: begin t.c = a;  t.s = b;  end
      2'd1: begin t.c = -b; t.s = a;  end
      2'd2: begin t.c = -a; t.s = -b; end
      default: begin t.c = b; t.s = -a; end
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ppm_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ppm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ppm_ctrl.sv @@
// Controller state machine of the particle pool manager.
// Sequences fire, tick, reverse and read requests; depends on ppm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppm_ctrl import ppm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] req_type,
  input  wire ppm_stat_t  stat,
  output ppm_cmd_t        cmd,
  output logic            busy
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_DECODE   = 12'b000000000010,
    S_FIRE_MUL = 12'b000000000100,
    S_FIRE_WR  = 12'b000000001000,
    S_LIST     = 12'b000000010000,
    S_OBJ      = 12'b000000100000,
    S_TMUL     = 12'b000001000000,
    S_TUPD     = 12'b000010000000,
    S_TAIL     = 12'b000100000000,
    S_RWR      = 12'b001000000000,
    S_RD_OBJ   = 12'b010000000000,
    S_RD_OUT   = 12'b100000000000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] op;

  // State and request code
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= REQ_FIRE;
    end else begin
      state <= state_next;
      if (state == S_IDLE && start) begin
        op <= req_type;
      end
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.emit_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (op)
          REQ_FIRE: begin
            if (stat.fs_empty) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_FULL;
              state_next      = S_IDLE;
            end else begin
              state_next = S_FIRE_MUL;
            end
          end
          REQ_READ: begin
            if (stat.ri_bad) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_BAD_READ;
              state_next      = S_IDLE;
            end else begin
              cmd.list_rd_ri = 1'b1;
              state_next     = S_RD_OBJ;
            end
          end
          default: state_next = S_LIST;
        endcase
      end
      S_FIRE_MUL: begin
        cmd.fs_rd    = 1'b1;
        cmd.mul_fire = 1'b1;
        state_next   = S_FIRE_WR;
      end
      S_FIRE_WR: begin
        cmd.fire_commit = 1'b1;
        cmd.emit        = 1'b1;
        state_next      = S_IDLE;
      end
      S_LIST: begin
        if (stat.i_end) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.list_rd_i = 1'b1;
          state_next    = S_OBJ;
        end
      end
      S_OBJ: begin
        cmd.obj_rd = 1'b1;
        state_next = (op == REQ_TICK) ? S_TMUL : S_RWR;
      end
      S_TMUL: begin
        cmd.mul_tick = 1'b1;
        state_next   = S_TUPD;
      end
      S_TUPD: begin
        cmd.upd_tick = 1'b1;
        state_next   = stat.cull ? S_TAIL : S_LIST;
      end
      S_TAIL: begin
        cmd.tail_wr = 1'b1;
        state_next  = S_LIST;
      end
      S_RWR: begin
        cmd.rev_wr = 1'b1;
        state_next = S_LIST;
      end
      S_RD_OBJ: begin
        cmd.obj_rd = 1'b1;
        state_next = S_RD_OUT;
      end
      S_RD_OUT: begin
        cmd.emit       = 1'b1;
        cmd.emit_entry = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/ppm_dpath.sv @@
// Datapath of the particle pool manager: object stores, free stack, active list,
// counters, shared multiplier pair and result registers. Depends on ppm_pkg, ppm_ram.
`timescale 1ns / 1ps
`default_nettype none

module ppm_dpath import ppm_pkg::*; #(
  parameter int POOL_SIZE = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ppm_cmd_t           cmd,
  output ppm_stat_t               stat,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic signed [19:0] pos_x,
  input  wire logic signed [19:0] pos_y,
  input  wire logic signed [10:0] speed,
  input  wire logic [6:0]         angle_step,
  input  wire logic [7:0]         owner,
  input  wire logic [15:0]        damage,
  input  wire logic [15:0]        radius,
  input  wire logic [15:0]        time_step,
  input  wire logic [9:0]         read_index,
  output logic                    done,
  output logic [1:0]              status,
  output logic [10:0]             active_total,
  output logic signed [19:0]      entry_x,
  output logic signed [19:0]      entry_y,
  output logic signed [17:0]      entry_vx,
  output logic signed [17:0]      entry_vy,
  output logic [7:0]              entry_owner,
  output logic [15:0]             entry_damage,
  output logic [15:0]             entry_radius
);

  localparam int IW   = $clog2(POOL_SIZE);
  localparam int CW   = $clog2(POOL_SIZE + 1);
  localparam int RIW  = ((CW > 10) ? CW : 10) + 1;
  localparam logic [CW-1:0] NCNT = CW'(POOL_SIZE);
  localparam logic [CW-1:0] LAST = CW'(POOL_SIZE - 1);

  // Configuration
  logic [15:0] screen_width;
  logic [15:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 16'd1920;
      screen_height <= 16'd1080;
    end else if (cfg_write) begin
      if (cfg_index == CFG_WIDTH) begin
        screen_width <= cfg_data;
      end else begin
        screen_height <= cfg_data;
      end
    end
  end

  // Captured request
  logic signed [19:0] rq_x;
  logic signed [19:0] rq_y;
  logic signed [12:0] rq_spd3;
  logic [6:0]         rq_angle;
  logic [39:0]        rq_attr;
  logic [15:0]        rq_dt;
  logic [9:0]         rq_ri;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rq_x     <= pos_x;
      rq_y     <= pos_y;
      rq_spd3  <= $signed({speed[10], speed, 1'b0}) + $signed({speed[10], speed[10], speed});
      rq_angle <= angle_step;
      rq_attr  <= {radius, damage, owner};
      rq_dt    <= time_step;
      rq_ri    <= read_index;
    end
  end

  // Counters
  logic [CW-1:0] ac;
  logic [CW-1:0] ac_next;
  logic [CW-1:0] fc;
  logic [CW-1:0] wm;
  logic [CW-1:0] i;
  logic [CW-1:0] pop_pos;
  logic          pop_virtual;
  logic          cull;

  assign pop_pos     = CW'(fc - CW'(1));
  assign pop_virtual = (pop_pos < wm);

  always_comb begin
    ac_next = ac;
    if (cmd.fire_commit) begin
      ac_next = CW'(ac + CW'(1));
    end else if (cmd.upd_tick && cull) begin
      ac_next = CW'(ac - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ac <= '0;
      fc <= NCNT;
      wm <= NCNT;
      i  <= '0;
    end else begin
      ac <= ac_next;
      if (cmd.fire_commit) begin
        fc <= pop_pos;
        if (pop_virtual) begin
          wm <= pop_pos;
        end
      end else if (cmd.upd_tick && cull && fc < NCNT) begin
        fc <= CW'(fc + CW'(1));
      end
      if (cmd.capture) begin
        i <= '0;
      end else if ((cmd.upd_tick && !cull) || cmd.rev_wr) begin
        i <= CW'(i + CW'(1));
      end
    end
  end

  // Memories
  logic [IW-1:0]      al_q;
  logic [IW-1:0]      fs_q;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      fire_idx;
  logic signed [19:0] px_q;
  logic signed [19:0] py_q;
  logic signed [17:0] vx_q;
  logic signed [17:0] vy_q;
  logic [39:0]        attr_q;

  logic          al_we;
  logic [IW-1:0] al_waddr;
  logic [IW-1:0] al_wdata;
  logic          al_re;
  logic [IW-1:0] al_raddr;

  assign fire_idx = pop_virtual ? IW'(LAST - pop_pos) : fs_q;

  // Active list port selection
  always_comb begin
    al_we    = cmd.fire_commit || cmd.tail_wr;
    al_waddr = cmd.fire_commit ? ac[IW-1:0] : i[IW-1:0];
    al_wdata = cmd.fire_commit ? fire_idx : al_q;
    al_re    = cmd.list_rd_i || cmd.list_rd_ri || (cmd.upd_tick && cull);
    if (cmd.list_rd_i) begin
      al_raddr = i[IW-1:0];
    end else if (cmd.list_rd_ri) begin
      al_raddr = IW'(rq_ri);
    end else begin
      al_raddr = IW'(ac - CW'(1));
    end
  end

  ppm_ram #(.WIDTH(IW), .DEPTH(POOL_SIZE)) u_active_list (
    .clk(clk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
    .re(al_re), .raddr(al_raddr), .rdata(al_q)
  );

  ppm_ram #(.WIDTH(IW), .DEPTH(POOL_SIZE)) u_free_stack (
    .clk(clk), .we(cmd.upd_tick && cull && fc < NCNT), .waddr(fc[IW-1:0]), .wdata(idx),
    .re(cmd.fs_rd), .raddr(pop_pos[IW-1:0]), .rdata(fs_q)
  );

  // Hold the slot under work
  always_ff @(posedge clk) begin
    if (cmd.obj_rd) begin
      idx <= al_q;
    end
  end

  // Shared multiplier pair
  ppm_trig_t          tr;
  logic signed [17:0] op_a0;
  logic signed [17:0] op_a1;
  logic signed [16:0] op_b0;
  logic signed [16:0] op_b1;
  logic signed [34:0] prod0;
  logic signed [34:0] prod1;

  assign tr = ppm_trig(rq_angle);

  always_comb begin
    if (cmd.mul_fire) begin
      op_a0 = 18'(rq_spd3);
      op_a1 = 18'(rq_spd3);
      op_b0 = 17'(tr.c);
      op_b1 = 17'(tr.s);
    end else begin
      op_a0 = vx_q;
      op_a1 = vy_q;
      op_b0 = $signed({1'b0, rq_dt});
      op_b1 = $signed({1'b0, rq_dt});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_fire || cmd.mul_tick) begin
      prod0 <= op_a0 * op_b0;
      prod1 <= op_a1 * op_b1;
    end
  end

  // Fire velocity: round half up, Q14 down to Q4
  logic signed [34:0] fv0;
  logic signed [34:0] fv1;
  assign fv0 = (prod0 + 35'sd512) >>> 10;
  assign fv1 = (prod1 + 35'sd512) >>> 10;

  // Tick motion with saturation
  logic signed [34:0] d0;
  logic signed [34:0] d1;
  logic signed [20:0] s0;
  logic signed [20:0] s1;
  logic signed [19:0] nx;
  logic signed [19:0] ny;

  assign d0 = (prod0 + 35'sd32768) >>> 16;
  assign d1 = (prod1 + 35'sd32768) >>> 16;
  assign s0 = 21'(px_q) + 21'($signed(d0[18:0]));
  assign s1 = 21'(py_q) + 21'($signed(d1[18:0]));

  always_comb begin
    if (s0 > 21'sd524287) begin
      nx = 20'sd524287;
    end else if (s0 < -21'sd524288) begin
      nx = -20'sd524288;
    end else begin
      nx = s0[19:0];
    end
    if (s1 > 21'sd524287) begin
      ny = 20'sd524287;
    end else if (s1 < -21'sd524288) begin
      ny = -20'sd524288;
    end else begin
      ny = s1[19:0];
    end
  end

  // Off-screen test
  assign cull = nx[19] || (nx[19:0] > {screen_width, 4'b0000}) ||
                ny[19] || (ny[19:0] > {screen_height, 4'b0000});

  // Object store ports
  logic [IW-1:0]      pos_waddr;
  logic signed [19:0] x_wdata;
  logic signed [19:0] y_wdata;
  logic [IW-1:0]      vel_waddr;
  logic signed [17:0] vx_wdata;
  logic signed [17:0] vy_wdata;

  assign pos_waddr = cmd.fire_commit ? fire_idx : idx;
  assign x_wdata   = cmd.fire_commit ? rq_x : nx;
  assign y_wdata   = cmd.fire_commit ? rq_y : ny;
  assign vel_waddr = cmd.fire_commit ? fire_idx : idx;
  assign vx_wdata  = cmd.fire_commit ? fv0[17:0] : 18'(-vx_q);
  assign vy_wdata  = cmd.fire_commit ? fv1[17:0] : 18'(-vy_q);

  ppm_ram #(.WIDTH(20), .DEPTH(POOL_SIZE)) u_pos_x (
    .clk(clk), .we(cmd.fire_commit || cmd.upd_tick), .waddr(pos_waddr), .wdata(x_wdata),
    .re(cmd.obj_rd), .raddr(al_q), .rdata(px_q)
  );

  ppm_ram #(.WIDTH(20), .DEPTH(POOL_SIZE)) u_pos_y (
    .clk(clk), .we(cmd.fire_commit || cmd.upd_tick), .waddr(pos_waddr), .wdata(y_wdata),
    .re(cmd.obj_rd), .raddr(al_q), .rdata(py_q)
  );

  ppm_ram #(.WIDTH(18), .DEPTH(POOL_SIZE)) u_vel_x (
    .clk(clk), .we(cmd.fire_commit || cmd.rev_wr), .waddr(vel_waddr), .wdata(vx_wdata),
    .re(cmd.obj_rd), .raddr(al_q), .rdata(vx_q)
  );

  ppm_ram #(.WIDTH(18), .DEPTH(POOL_SIZE)) u_vel_y (
    .clk(clk), .we(cmd.fire_commit || cmd.rev_wr), .waddr(vel_waddr), .wdata(vy_wdata),
    .re(cmd.obj_rd), .raddr(al_q), .rdata(vy_q)
  );

  ppm_ram #(.WIDTH(40), .DEPTH(POOL_SIZE)) u_attrs (
    .clk(clk), .we(cmd.fire_commit), .waddr(fire_idx), .wdata(rq_attr),
    .re(cmd.obj_rd), .raddr(al_q), .rdata(attr_q)
  );

  // Status to the controller
  assign stat.fs_empty = (fc == '0);
  assign stat.i_end    = (i >= ac);
  assign stat.ri_bad   = (RIW'(rq_ri) >= RIW'(ac));
  assign stat.cull     = cull;

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status       <= cmd.emit_status;
      active_total <= 11'(ac_next);
      if (cmd.emit_entry) begin
        entry_x      <= px_q;
        entry_y      <= py_q;
        entry_vx     <= vx_q;
        entry_vy     <= vy_q;
        entry_owner  <= attr_q[7:0];
        entry_damage <= attr_q[23:8];
        entry_radius <= attr_q[39:24];
      end else begin
        entry_x      <= '0;
        entry_y      <= '0;
        entry_vx     <= '0;
        entry_vy     <= '0;
        entry_owner  <= '0;
        entry_damage <= '0;
        entry_radius <= '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/particle_pool_manager.sv @@
// Particle pool manager top level. Steps from start to the registered done strobe:
// fire decodes, multiplies and commits; read decodes, reads list and object and emits;
// full fire/bad read end at decode; reverse and tick walk the list, culls add a tail move.
// One request at a time: start is taken while busy is low; the result strobe cannot stall.
// Synchronous reset empties the pool (all slots free) and restores 1920 x 1080.
// Depends on ppm_pkg, ppm_ctrl, ppm_dpath, ppm_ram.
`timescale 1ns / 1ps
`default_nettype none

module particle_pool_manager import ppm_pkg::*; #(
  parameter int POOL_SIZE = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [19:0] pos_x,
  input  wire logic signed [19:0] pos_y,
  input  wire logic signed [10:0] speed,
  input  wire logic [6:0]         angle_step,
  input  wire logic [7:0]         owner,
  input  wire logic [15:0]        damage,
  input  wire logic [15:0]        radius,
  input  wire logic [15:0]        time_step,
  input  wire logic [9:0]         read_index,
  output logic                    done,
  output logic [1:0]              status,
  output logic [10:0]             active_total,
  output logic signed [19:0]      entry_x,
  output logic signed [19:0]      entry_y,
  output logic signed [17:0]      entry_vx,
  output logic signed [17:0]      entry_vy,
  output logic [7:0]              entry_owner,
  output logic [15:0]             entry_damage,
  output logic [15:0]             entry_radius
);

  ppm_cmd_t  cmd;
  ppm_stat_t stat;

  // Sequencer
  ppm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .req_type(req_type),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  // Stores, arithmetic and result transfer
  ppm_dpath #(.POOL_SIZE(POOL_SIZE)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pos_x(pos_x), .pos_y(pos_y), .speed(speed), .angle_step(angle_step),
    .owner(owner), .damage(damage), .radius(radius), .time_step(time_step),
    .read_index(read_index),
    .done(done), .status(status), .active_total(active_total),
    .entry_x(entry_x), .entry_y(entry_y), .entry_vx(entry_vx), .entry_vy(entry_vy),
    .entry_owner(entry_owner), .entry_damage(entry_damage), .entry_radius(entry_radius)
  );

endmodule

`default_nettype wire
